### rtl/mpks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpks_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int IDX_WIDTH   = 3;
    localparam int PHASE_WIDTH = 3;
    localparam int KEY_WIDTH   = 2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // sequencer phases
    localparam logic [PHASE_WIDTH-1:0] PH_CHECK       = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_ON_PULL     = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_ON_RELEASE  = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_WAIT_ON     = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_OFF_PULL    = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_OFF_RELEASE = 3'd5;
    localparam logic [PHASE_WIDTH-1:0] PH_WAIT_OFF    = 3'd6;

    // key actions
    localparam logic [KEY_WIDTH-1:0] KEY_NONE    = 2'd0;
    localparam logic [KEY_WIDTH-1:0] KEY_PULL    = 2'd1;
    localparam logic [KEY_WIDTH-1:0] KEY_RELEASE = 2'd2;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_ON_LOW      = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_ON_RELEASE  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_OFF_LOW     = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_OFF_RELEASE = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_OFF_POLL    = 3'd4;

    localparam logic [CFG_WIDTH-1:0] ON_LOW_RST      = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] ON_RELEASE_RST  = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] OFF_LOW_RST     = 16'd2500;
    localparam logic [CFG_WIDTH-1:0] OFF_RELEASE_RST = 16'd3000;
    localparam logic [CFG_WIDTH-1:0] OFF_POLL_RST    = 16'd50;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] on_low;
        logic [CFG_WIDTH-1:0] on_release;
        logic [CFG_WIDTH-1:0] off_low;
        logic [CFG_WIDTH-1:0] off_release;
        logic [CFG_WIDTH-1:0] off_poll;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_WIDTH-1:0] phase;
        logic [COUNT_WIDTH-1:0] elapsed;
        logic [COUNT_WIDTH-1:0] wait_ms;
    } seq_state_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key_action;
        logic                   power_up_done;
        logic [PHASE_WIDTH-1:0] phase_now;
    } result_t;

    // load a wait so that the saturating counter can always reach it
    function automatic logic [COUNT_WIDTH-1:0] clamp_wait(input logic [CFG_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        if (32'(v) > 32'(CNT_MAX))
        begin
            r = CNT_MAX;
        end
        else
        begin
            r = COUNT_WIDTH'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mpks_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mpks_step (
    input  wire mpks_pkg::cfg_t       cfg,
    input  wire mpks_pkg::seq_state_t cur,
    input  wire logic                 modem_status,
    output mpks_pkg::seq_state_t      nxt,
    output mpks_pkg::result_t         res
);

    logic [mpks_pkg::COUNT_WIDTH-1:0] count;

    always_comb
    begin
        if (cur.elapsed != mpks_pkg::CNT_MAX)
        begin
            count = cur.elapsed + 1'b1;
        end
        else
        begin
            count = cur.elapsed;
        end

        nxt               = cur;
        nxt.elapsed       = count;
        res.key_action    = mpks_pkg::KEY_NONE;
        res.power_up_done = 1'b0;

        if (count >= cur.wait_ms)
        begin
            nxt.elapsed = '0;
            case (cur.phase)
                mpks_pkg::PH_CHECK:
                begin
                    nxt.phase   = modem_status ? mpks_pkg::PH_OFF_PULL : mpks_pkg::PH_ON_PULL;
                    nxt.wait_ms = '0;
                end
                mpks_pkg::PH_ON_PULL:
                begin
                    res.key_action = mpks_pkg::KEY_PULL;
                    nxt.wait_ms    = mpks_pkg::clamp_wait(cfg.on_low);
                    nxt.phase      = mpks_pkg::PH_ON_RELEASE;
                end
                mpks_pkg::PH_ON_RELEASE:
                begin
                    res.key_action = mpks_pkg::KEY_RELEASE;
                    nxt.wait_ms    = mpks_pkg::clamp_wait(cfg.on_release);
                    nxt.phase      = mpks_pkg::PH_WAIT_ON;
                end
                mpks_pkg::PH_WAIT_ON:
                begin
                    // wait keeps the on-release value, so the next check waits that long
                    if (modem_status)
                    begin
                        nxt.phase         = mpks_pkg::PH_CHECK;
                        res.power_up_done = 1'b1;
                    end
                end
                mpks_pkg::PH_OFF_PULL:
                begin
                    res.key_action = mpks_pkg::KEY_PULL;
                    nxt.wait_ms    = mpks_pkg::clamp_wait(cfg.off_low);
                    nxt.phase      = mpks_pkg::PH_OFF_RELEASE;
                end
                mpks_pkg::PH_OFF_RELEASE:
                begin
                    res.key_action = mpks_pkg::KEY_RELEASE;
                    nxt.wait_ms    = mpks_pkg::clamp_wait(cfg.off_release);
                    nxt.phase      = mpks_pkg::PH_WAIT_OFF;
                end
                mpks_pkg::PH_WAIT_OFF:
                begin
                    nxt.wait_ms = mpks_pkg::clamp_wait(cfg.off_poll);
                    if (!modem_status)
                    begin
                        nxt.phase = mpks_pkg::PH_ON_PULL;
                    end
                end
                default:
                begin
                    // unused phase: only the counter restarts
                end
            endcase
        end

        res.phase_now = nxt.phase;
    end

endmodule

`default_nettype wire

### rtl/modem_power_key_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Modem power-key sequencer, one input item per millisecond tick.
// Input channel (in_valid / in_stall): modem_status, the status pin level.
// Output channel (out_valid / out_stall): key_action, power_up_done and
// phase_now, exactly one result item for each input item.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; indexes 0..4 select the hold and poll times, others are ignored.
// Write configuration only while no item is in flight.
// The result is registered and appears in the cycle after the input item is accepted.
// Throughput: one item per cycle while in_stall is low; the phase update is a single compare
// and increment between the state registers and the result register.
// While the receiver stalls, the held result stays put and in_stall is raised
// only when the result register is full and stalled, so an item can still be
// taken in the cycle the result drains.
// Reset: phase returns to check, counter and wait clear (the first tick acts),
// registers take their default times and the result register empties.

module modem_power_key_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               modem_status,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [mpks_pkg::KEY_WIDTH-1:0]          key_action,
    output logic                                    power_up_done,
    output logic [mpks_pkg::PHASE_WIDTH-1:0]        phase_now,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mpks_pkg::IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [mpks_pkg::CFG_WIDTH-1:0]     cfg_data
);

    mpks_pkg::cfg_t       cfg_reg;
    mpks_pkg::seq_state_t state_reg;
    mpks_pkg::seq_state_t state_next;
    mpks_pkg::result_t    res_next;
    mpks_pkg::result_t    res_reg;
    logic                 out_valid_reg;
    logic                 in_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_low      <= mpks_pkg::ON_LOW_RST;
            cfg_reg.on_release  <= mpks_pkg::ON_RELEASE_RST;
            cfg_reg.off_low     <= mpks_pkg::OFF_LOW_RST;
            cfg_reg.off_release <= mpks_pkg::OFF_RELEASE_RST;
            cfg_reg.off_poll    <= mpks_pkg::OFF_POLL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mpks_pkg::REG_ON_LOW:      cfg_reg.on_low      <= cfg_data;
                mpks_pkg::REG_ON_RELEASE:  cfg_reg.on_release  <= cfg_data;
                mpks_pkg::REG_OFF_LOW:     cfg_reg.off_low     <= cfg_data;
                mpks_pkg::REG_OFF_RELEASE: cfg_reg.off_release <= cfg_data;
                mpks_pkg::REG_OFF_POLL:    cfg_reg.off_poll    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mpks_step u_step (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .modem_status (modem_status),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase   <= mpks_pkg::PH_CHECK;
            state_reg.elapsed <= '0;
            state_reg.wait_ms <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg <= state_next;
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_action    = res_reg.key_action;
    assign power_up_done = res_reg.power_up_done;
    assign phase_now     = res_reg.phase_now;

endmodule

`default_nettype wire

### test/modem_power_key_sequencer_checker.sv
`timescale 1ns / 1ps

module modem_power_key_sequencer_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               modem_status,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [mpks_pkg::KEY_WIDTH-1:0]     key_action,
    input  logic                               power_up_done,
    input  logic [mpks_pkg::PHASE_WIDTH-1:0]   phase_now,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mpks_pkg::IDX_WIDTH-1:0]     cfg_index,
    input  logic [mpks_pkg::CFG_WIDTH-1:0]     cfg_data,
    output int                                 pending,
    output int                                 fails
);
    import mpks_pkg::*;

    cfg_t                   hold_times;
    logic [PHASE_WIDTH-1:0] seq_phase;
    logic [COUNT_WIDTH-1:0] ms_count;
    logic [COUNT_WIDTH-1:0] ms_wait;
    result_t                tick_results [$];
    int                     outstanding = 0;
    int                     fail_count = 0;

    assign pending = outstanding;
    assign fails   = fail_count;

    function automatic logic [COUNT_WIDTH-1:0] fit_wait(input logic [CFG_WIDTH-1:0] ms);
        return (ms > CNT_MAX) ? CNT_MAX : COUNT_WIDTH'(ms);
    endfunction

    // advance the sequencer copy by one millisecond tick
    function automatic result_t advance_tick(input logic status);
        result_t r;
        r.key_action    = KEY_NONE;
        r.power_up_done = 1'b0;
        if (ms_count != CNT_MAX)
        begin
            ms_count = ms_count + 1'b1;
        end
        if (ms_count >= ms_wait)
        begin
            ms_count = '0;
            case (seq_phase)
                PH_CHECK:
                begin
                    seq_phase = status ? PH_OFF_PULL : PH_ON_PULL;
                    ms_wait   = '0;
                end
                PH_ON_PULL:
                begin
                    r.key_action = KEY_PULL;
                    ms_wait      = fit_wait(hold_times.on_low);
                    seq_phase    = PH_ON_RELEASE;
                end
                PH_ON_RELEASE:
                begin
                    r.key_action = KEY_RELEASE;
                    ms_wait      = fit_wait(hold_times.on_release);
                    seq_phase    = PH_WAIT_ON;
                end
                PH_WAIT_ON:
                begin
                    // wait is left alone, so the next check takes on_release
                    if (status)
                    begin
                        seq_phase       = PH_CHECK;
                        r.power_up_done = 1'b1;
                    end
                end
                PH_OFF_PULL:
                begin
                    r.key_action = KEY_PULL;
                    ms_wait      = fit_wait(hold_times.off_low);
                    seq_phase    = PH_OFF_RELEASE;
                end
                PH_OFF_RELEASE:
                begin
                    r.key_action = KEY_RELEASE;
                    ms_wait      = fit_wait(hold_times.off_release);
                    seq_phase    = PH_WAIT_OFF;
                end
                PH_WAIT_OFF:
                begin
                    ms_wait = fit_wait(hold_times.off_poll);
                    if (!status)
                    begin
                        seq_phase = PH_ON_PULL;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.phase_now = seq_phase;
        return r;
    endfunction

    task automatic flag_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            hold_times.on_low      = ON_LOW_RST;
            hold_times.on_release  = ON_RELEASE_RST;
            hold_times.off_low     = OFF_LOW_RST;
            hold_times.off_release = OFF_RELEASE_RST;
            hold_times.off_poll    = OFF_POLL_RST;
            seq_phase              = PH_CHECK;
            ms_count               = '0;
            ms_wait                = '0;
            tick_results.delete();
            outstanding            = 0;
        end
        else
        begin
            // results leave before this edge's item is predicted
            if (out_valid && !out_stall)
            begin
                if (tick_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual key %0d done %0d phase %0d",
                             $time, key_action, power_up_done, phase_now);
                    fail_count++;
                end
                else
                begin
                    want = tick_results.pop_front();
                    if (key_action !== want.key_action)
                    begin
                        flag_field("key_action", want.key_action, key_action);
                    end
                    if (power_up_done !== want.power_up_done)
                    begin
                        flag_field("power_up_done", want.power_up_done, power_up_done);
                    end
                    if (phase_now !== want.phase_now)
                    begin
                        flag_field("phase_now", want.phase_now, phase_now);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                tick_results.push_back(advance_tick(modem_status));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ON_LOW:      hold_times.on_low      = cfg_data;
                    REG_ON_RELEASE:  hold_times.on_release  = cfg_data;
                    REG_OFF_LOW:     hold_times.off_low     = cfg_data;
                    REG_OFF_RELEASE: hold_times.off_release = cfg_data;
                    REG_OFF_POLL:    hold_times.off_poll    = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            outstanding = tick_results.size();
        end
    end

endmodule

### test/tb_modem_power_key_sequencer.sv
`timescale 1ns / 1ps

module tb_modem_power_key_sequencer;
    import mpks_pkg::*;

    localparam int LIMIT = 500000;
    // indexes above the last register are ignored by the block
    localparam logic [IDX_WIDTH-1:0] REG_SPARE = 3'd7;
    // status levels walked with every wait at zero, oldest bit first
    localparam logic [19:0] STATUS_WALK = 20'b1000_0111_1101_1100_0101;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   modem_status;
    logic                   out_valid;
    logic                   out_stall;
    logic [KEY_WIDTH-1:0]   key_action;
    logic                   power_up_done;
    logic [PHASE_WIDTH-1:0] phase_now;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_WIDTH-1:0]   cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;
    int                     pending;
    int                     fails;
    int                     cycles;
    bit                     no_idle;
    logic                   line_level;

    modem_power_key_sequencer uut (.*);

    modem_power_key_sequencer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall before each result
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_tick(input logic status);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        modem_status <= status;
        do @(posedge clk); while (in_stall);
    endtask

    // mostly a slowly changing pin level, with some noise ticks
    task automatic random_ticks(input int count);
        logic status;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                no_idle = ~no_idle;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                line_level = ~line_level;
            end
            status = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : line_level;
            send_tick(status);
        end
        no_idle = 1'b0;
    endtask

    // one edge first so the checker has seen the last accepted item
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_times(input logic [CFG_WIDTH-1:0] on_low,
                                 input logic [CFG_WIDTH-1:0] on_rel,
                                 input logic [CFG_WIDTH-1:0] off_low,
                                 input logic [CFG_WIDTH-1:0] off_rel,
                                 input logic [CFG_WIDTH-1:0] poll);
        logic [IDX_WIDTH-1:0] sel [6];
        logic [CFG_WIDTH-1:0] val [6];
        sel = '{REG_ON_LOW, REG_ON_RELEASE, REG_OFF_LOW, REG_OFF_RELEASE, REG_OFF_POLL,
                REG_SPARE};
        val = '{on_low, on_rel, off_low, off_rel, poll, CFG_WIDTH'($urandom)};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= sel[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_ms(input int upper);
        return CFG_WIDTH'($urandom_range(0, upper));
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        modem_status = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_ON_LOW;
        cfg_data     = '0;
        no_idle      = 1'b0;
        line_level   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // first tick acts on check at once; the pull then loads the programmed hold
        send_tick(1'b1);
        settle();
        program_times('0, '0, '0, '0, '0);

        for (int i = 19; i >= 0; i--)
        begin
            send_tick(STATUS_WALK[i]);
        end
        random_ticks(200);

        settle();
        program_times(pick_ms(6), pick_ms(6), pick_ms(6), pick_ms(6), pick_ms(6));
        random_ticks(250);

        settle();
        program_times(pick_ms(40), pick_ms(40), pick_ms(40), pick_ms(40), pick_ms(40));
        random_ticks(250);

        // long on hold against short other times
        settle();
        program_times(16'd200, 16'd1, 16'd2, 16'd1, 16'd3);
        random_ticks(250);

        settle();
        repeat (10) @(posedge clk);
        if (fails == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/mpks_pkg.sv
rtl/mpks_step.sv
rtl/modem_power_key_sequencer.sv
test/modem_power_key_sequencer_checker.sv
test/tb_modem_power_key_sequencer.sv
